// ===== src/pid_controller_variable_dt_core_assert.svh =====
// Assertion macros shared by the PID core RTL.
// Needs clk_i and rst_ni in the including module's scope.
`ifndef PID_CONTROLLER_VARIABLE_DT_CORE_ASSERT_SVH
`define PID_CONTROLLER_VARIABLE_DT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PIDVDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PIDVDT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PIDVDT_ASSERT(lbl, prop, msg)
`define PIDVDT_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== src/pidvdt_pkg.sv =====
// Shared widths, constants, microcode control word and register codes
// for the variable-time-step PID core. No dependencies.
package pidvdt_pkg;

  localparam int unsigned ValW      = 16;  // setpoint, measured, elapsed_ms, gains
  localparam int unsigned ErrW      = 17;  // setpoint - measured
  localparam int unsigned DerrW     = 18;  // error change
  localparam int unsigned IntW      = 48;  // integral accumulator
  localparam int unsigned MulAW     = 27;  // multiplier operand a
  localparam int unsigned MulBW     = 18;  // multiplier operand b
  localparam int unsigned ProdW     = MulAW + MulBW;
  localparam int unsigned AccW      = 64;  // wide accumulators, dividend
  localparam int unsigned DriveW    = 32;
  localparam int unsigned FracShift = 12;  // Q.20 terms -> Q24.8 drive
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned TDataInW  = 2 * ValW;
  localparam int unsigned DivBits   = 2;   // quotient bits per cycle
  localparam int unsigned DivSteps  = AccW / DivBits;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam int unsigned PcW       = 4;

  localparam logic [ValW-1:0] SetpointReset = 16'd0;
  localparam logic [ValW-1:0] GainPReset    = 16'd3277;
  localparam logic [ValW-1:0] GainIReset    = 16'd410;
  localparam logic [ValW-1:0] GainDReset    = 16'd1229;
  localparam logic [ValW-1:0] KMilli        = 16'd1000;

  typedef logic [PcW-1:0] pc_t;

  localparam pc_t PcIdle  = 4'd0;
  localparam pc_t PcClear = 4'd13;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETPOINT = 2'd0,
    REG_GAIN_P   = 2'd1,
    REG_GAIN_I   = 2'd2,
    REG_GAIN_D   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,      // fall through
    SEQ_ACCEPT,    // wait for a word; clear words jump to target
    SEQ_WAIT_DIV,  // hold while the divider runs
    SEQ_WAIT_OUT   // hold while the output register is full, then jump
  } seq_e;

  typedef enum logic [2:0] {
    MA_ERR, MA_GAIN_P, MA_GAIN_I, MA_GAIN_D, MA_PROD
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_MS, MB_ERR, MB_INT_LO, MB_INT_MID, MB_INT_HI, MB_MILLI, MB_DERR
  } mul_b_e;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD16, ACC_ADD32} acc_op_e;
  typedef enum logic [1:0] {SUM_HOLD, SUM_LOAD, SUM_ADD_QUO} sum_op_e;
  typedef enum logic [1:0] {DIV_NONE, DIV_START_INT, DIV_START_DER} div_op_e;
  typedef enum logic [1:0] {ST_HOLD, ST_INTEG, ST_FINISH, ST_CLEAR} st_op_e;

  typedef struct packed {
    seq_e    seq;
    pc_t     target;
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    logic    mul_en;
    acc_op_e acc_op;
    sum_op_e sum_op;
    div_op_e div_op;
    st_op_e  st_op;
  } ctrl_t;

endpackage

// ===== src/pidvdt_div.sv =====
// Radix-4 restoring divider: floor division of a signed 64-bit dividend
// by a positive 16-bit divisor. Depends on pidvdt_pkg.
`include "pid_controller_variable_dt_core_assert.svh"

module pidvdt_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pidvdt_pkg::AccW-1:0]  dividend_i,
  input  logic [pidvdt_pkg::ValW-1:0]  divisor_i,
  output logic                         busy_o,
  output logic [pidvdt_pkg::AccW-1:0]  quot_o
);
  import pidvdt_pkg::*;

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic [ValW-1:0]    rem_q, rem_d, dv_q, dv_d;
  logic [AccW-1:0]    sh_q, sh_d;
  logic [ValW:0]      t1, t2;
  logic [ValW-1:0]    r1;
  logic               q1, q2;

  // floor(x/d) for x < 0 is ~(~x / d), so only magnitudes get divided
  always_comb begin
    t1 = {rem_q, sh_q[AccW-1]};
    q1 = (t1 >= {1'b0, dv_q});
    r1 = q1 ? ValW'(t1 - {1'b0, dv_q}) : t1[ValW-1:0];
    t2 = {r1, sh_q[AccW-2]};
    q2 = (t2 >= {1'b0, dv_q});

    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[AccW-1];
      sh_d   = dividend_i[AccW-1] ? ~dividend_i : dividend_i;
      rem_d  = '0;
      dv_d   = divisor_i;
    end else if (busy_q) begin
      rem_d = q2 ? ValW'(t2 - {1'b0, dv_q}) : t2[ValW-1:0];
      sh_d  = {sh_q[AccW-3:0], q1, q2};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
    sh_q  <= sh_d;
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? ~sh_q : sh_q;

  `PIDVDT_ASSERT_NEVER(a_div_restart, start_i && busy_q, "divider restarted while busy")
  `PIDVDT_ASSERT(a_div_ends, busy_q && (cnt_q == DivCntW'(DivSteps - 1)) |=> !busy_q, "divider overran")
  `PIDVDT_ASSERT(a_div_rem, busy_q |-> (rem_q < dv_q), "partial remainder not below divisor")

endmodule

// ===== src/pidvdt_ucode.sv =====
// Microcode ROM of the PID core: one control word per program step.
// Depends on pidvdt_pkg.
module pidvdt_ucode (
  input  pidvdt_pkg::pc_t   pc_i,
  output pidvdt_pkg::ctrl_t ctrl_o
);
  import pidvdt_pkg::*;

  function automatic ctrl_t cw(seq_e s, pc_t tgt, mul_a_e a, mul_b_e b, logic en,
                               acc_op_e ao, sum_op_e so, div_op_e dop, st_op_e st);
    cw = '{seq: s, target: tgt, mul_a: a, mul_b: b, mul_en: en,
           acc_op: ao, sum_op: so, div_op: dop, st_op: st};
  endfunction

  always_comb begin
    case (pc_i)
      // idle: take a word; clear jumps away
      4'd0:  ctrl_o = cw(SEQ_ACCEPT, PcClear, MA_ERR, MB_MS, 1'b0,
                         ACC_HOLD, SUM_HOLD, DIV_NONE, ST_HOLD);
      // e * ms
      4'd1:  ctrl_o = cw(SEQ_NEXT, PcIdle, MA_ERR, MB_MS, 1'b1,
                         ACC_HOLD, SUM_HOLD, DIV_NONE, ST_HOLD);
      // integrate with clipping; kp * e
      4'd2:  ctrl_o = cw(SEQ_NEXT, PcIdle, MA_GAIN_P, MB_ERR, 1'b1,
                         ACC_HOLD, SUM_HOLD, DIV_NONE, ST_INTEG);
      // sum = P; ki * integral, low slice
      4'd3:  ctrl_o = cw(SEQ_NEXT, PcIdle, MA_GAIN_I, MB_INT_LO, 1'b1,
                         ACC_HOLD, SUM_LOAD, DIV_NONE, ST_HOLD);
      4'd4:  ctrl_o = cw(SEQ_NEXT, PcIdle, MA_GAIN_I, MB_INT_MID, 1'b1,
                         ACC_LOAD, SUM_HOLD, DIV_NONE, ST_HOLD);
      4'd5:  ctrl_o = cw(SEQ_NEXT, PcIdle, MA_GAIN_I, MB_INT_HI, 1'b1,
                         ACC_ADD16, SUM_HOLD, DIV_NONE, ST_HOLD);
      // finish ki * integral; kd * 1000
      4'd6:  ctrl_o = cw(SEQ_NEXT, PcIdle, MA_GAIN_D, MB_MILLI, 1'b1,
                         ACC_ADD32, SUM_HOLD, DIV_NONE, ST_HOLD);
      // I term: divide by 1000; kd * 1000 * de
      4'd7:  ctrl_o = cw(SEQ_NEXT, PcIdle, MA_PROD, MB_DERR, 1'b1,
                         ACC_HOLD, SUM_HOLD, DIV_START_INT, ST_HOLD);
      4'd8:  ctrl_o = cw(SEQ_WAIT_DIV, PcIdle, MA_ERR, MB_MS, 1'b0,
                         ACC_HOLD, SUM_HOLD, DIV_NONE, ST_HOLD);
      // add I; D term: divide by elapsed time
      4'd9:  ctrl_o = cw(SEQ_NEXT, PcIdle, MA_ERR, MB_MS, 1'b0,
                         ACC_HOLD, SUM_ADD_QUO, DIV_START_DER, ST_HOLD);
      4'd10: ctrl_o = cw(SEQ_WAIT_DIV, PcIdle, MA_ERR, MB_MS, 1'b0,
                         ACC_HOLD, SUM_HOLD, DIV_NONE, ST_HOLD);
      4'd11: ctrl_o = cw(SEQ_NEXT, PcIdle, MA_ERR, MB_MS, 1'b0,
                         ACC_HOLD, SUM_ADD_QUO, DIV_NONE, ST_HOLD);
      // scale, clip, emit
      4'd12: ctrl_o = cw(SEQ_WAIT_OUT, PcIdle, MA_ERR, MB_MS, 1'b0,
                         ACC_HOLD, SUM_HOLD, DIV_NONE, ST_FINISH);
      // clear word
      4'd13: ctrl_o = cw(SEQ_WAIT_OUT, PcIdle, MA_ERR, MB_MS, 1'b0,
                         ACC_HOLD, SUM_HOLD, DIV_NONE, ST_CLEAR);
      default: ctrl_o = cw(SEQ_NEXT, PcIdle, MA_ERR, MB_MS, 1'b0,
                           ACC_HOLD, SUM_HOLD, DIV_NONE, ST_HOLD);
    endcase
  end

endmodule

// ===== src/pidvdt_dpath.sv =====
// PID datapath: shared 27x18 multiplier, integral and error state,
// wide accumulators and the divider. Depends on pidvdt_pkg, pidvdt_div.
module pidvdt_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pidvdt_pkg::ctrl_t           ctrl_i,
  input  logic [pidvdt_pkg::ValW-1:0] setpoint_i,
  input  logic [pidvdt_pkg::ValW-1:0] gain_p_i,
  input  logic [pidvdt_pkg::ValW-1:0] gain_i_i,
  input  logic [pidvdt_pkg::ValW-1:0] gain_d_i,
  input  logic [pidvdt_pkg::ValW-1:0] measured_i,
  input  logic [pidvdt_pkg::ValW-1:0] elapsed_ms_i,
  output logic                        div_busy_o,
  output logic [pidvdt_pkg::DriveW-1:0] drive_o,
  output logic                        saturated_o
);
  import pidvdt_pkg::*;

  localparam int unsigned HiLsb = DriveW + FracShift - 1;

  logic [ErrW-1:0]  err;
  logic [DerrW-1:0] derr;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [AccW-1:0]  prod_ext;
  logic [IntW-1:0]  int_q, int_d;
  logic [IntW:0]    int_sum;
  logic             int_ovf;
  logic [ErrW-1:0]  last_err_q, last_err_d;
  logic             clip_q, clip_d;
  logic [AccW-1:0]  acc_q, acc_d, sum_q, sum_d;
  logic             div_start;
  logic [AccW-1:0]  div_dividend, quot;
  logic [ValW-1:0]  div_divisor;
  logic             in_range;

  assign err  = {setpoint_i[ValW-1], setpoint_i} - {measured_i[ValW-1], measured_i};
  assign derr = {err[ErrW-1], err} - {last_err_q[ErrW-1], last_err_q};

  always_comb begin
    case (ctrl_i.mul_a)
      MA_ERR:    mul_a = {{(MulAW-ErrW){err[ErrW-1]}}, err};
      MA_GAIN_P: mul_a = {{(MulAW-ValW){1'b0}}, gain_p_i};
      MA_GAIN_I: mul_a = {{(MulAW-ValW){1'b0}}, gain_i_i};
      MA_GAIN_D: mul_a = {{(MulAW-ValW){1'b0}}, gain_d_i};
      MA_PROD:   mul_a = prod_q[MulAW-1:0];  // kd*1000 < 2^26
      default:   mul_a = '0;
    endcase
    case (ctrl_i.mul_b)
      MB_MS:      mul_b = {{(MulBW-ValW){1'b0}}, elapsed_ms_i};
      MB_ERR:     mul_b = {{(MulBW-ErrW){err[ErrW-1]}}, err};
      MB_INT_LO:  mul_b = {{(MulBW-ValW){1'b0}}, int_q[ValW-1:0]};
      MB_INT_MID: mul_b = {{(MulBW-ValW){1'b0}}, int_q[2*ValW-1:ValW]};
      MB_INT_HI:  mul_b = {{(MulBW-ValW){int_q[IntW-1]}}, int_q[IntW-1:2*ValW]};
      MB_MILLI:   mul_b = {{(MulBW-ValW){1'b0}}, KMilli};
      MB_DERR:    mul_b = derr;
      default:    mul_b = '0;
    endcase
  end

  assign prod_d   = ctrl_i.mul_en ? ProdW'($signed(mul_a) * $signed(mul_b)) : prod_q;
  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  // integral update, clipped to 48 bits
  assign int_sum = {int_q[IntW-1], int_q} + prod_ext[IntW:0];
  assign int_ovf = int_sum[IntW] != int_sum[IntW-1];

  always_comb begin
    int_d      = int_q;
    last_err_d = last_err_q;
    clip_d     = clip_q;
    case (ctrl_i.st_op)
      ST_INTEG: begin
        clip_d = int_ovf;
        if (int_ovf) begin
          int_d = int_sum[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
        end else begin
          int_d = int_sum[IntW-1:0];
        end
      end
      ST_FINISH: last_err_d = err;
      ST_CLEAR: begin
        int_d      = '0;
        last_err_d = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD:  acc_d = prod_ext;
      ACC_ADD16: acc_d = acc_q + (prod_ext << ValW);
      ACC_ADD32: acc_d = acc_q + (prod_ext << (2 * ValW));
      default:   acc_d = acc_q;
    endcase
    case (ctrl_i.sum_op)
      SUM_LOAD:    sum_d = prod_ext;
      SUM_ADD_QUO: sum_d = sum_q + quot;
      default:     sum_d = sum_q;
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    case (ctrl_i.div_op)
      DIV_START_INT: begin
        div_dividend = acc_q;
        div_divisor  = KMilli;
      end
      DIV_START_DER: begin
        div_dividend = prod_ext;
        div_divisor  = (elapsed_ms_i == '0) ? ValW'(1) : elapsed_ms_i;
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = acc_q;
        div_divisor  = KMilli;
      end
    endcase
  end

  pidvdt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy_o),
    .quot_o     (quot)
  );

  // drive = sum >>> 12, clipped to 32 bits
  assign in_range = (&sum_q[AccW-1:HiLsb]) | ~(|sum_q[AccW-1:HiLsb]);
  assign drive_o  = in_range ? sum_q[HiLsb:FracShift] :
                    (sum_q[AccW-1] ? {1'b1, {(DriveW-1){1'b0}}} : {1'b0, {(DriveW-1){1'b1}}});
  assign saturated_o = clip_q | ~in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q      <= '0;
      last_err_q <= '0;
      clip_q     <= 1'b0;
    end else begin
      int_q      <= int_d;
      last_err_q <= last_err_d;
      clip_q     <= clip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    sum_q  <= sum_d;
  end

endmodule

// ===== src/pid_controller_variable_dt_core.sv =====
// Top level of the variable-time-step PID core: stream ports, config
// registers, microcode sequencer and output register.
// Depends on pidvdt_pkg, pidvdt_ucode, pidvdt_dpath.
//
// Positional PID step with variable dt. A compute word (tuser = 0) carries
// the measurement (signed Q8.8) and the elapsed milliseconds; the result is
// drive = kp*e + ki*I/1000 + kd*de*1000/ms in signed Q24.8, clipped to 32
// bits, with tuser set when the drive or the 48-bit integral clipped. A clear
// word (tuser = 1) zeroes integral and previous error and returns drive 0.
// One word is in flight at a time. From accept to result a compute word runs
// seven multiply/accumulate steps on the shared 27x18 multiplier plus two
// runs of the radix-4 divider (by 1000 for the integral term, by the elapsed
// time for the derivative term). The result sits in an output register, so
// the next word is taken while a result waits. Elapsed time 0 adds nothing to
// the integral and divides the derivative by 1. Configuration writes
// (setpoint, kp, ki, kd in Q4.12) belong between words.
`include "pid_controller_variable_dt_core_assert.svh"

module pid_controller_variable_dt_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [pidvdt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pidvdt_pkg::ValW-1:0]          cfg_data_i,
  // input words
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pidvdt_pkg::TDataInW-1:0]      s_axis_tdata,  // measured, elapsed_ms
  input  logic                                 s_axis_tuser,  // req_type
  // result words
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pidvdt_pkg::DriveW-1:0]        m_axis_tdata,  // drive
  output logic                                 m_axis_tuser   // saturated
);
  import pidvdt_pkg::*;

  logic [ValW-1:0] setpoint_q, gain_p_q, gain_i_q, gain_d_q;
  logic [ValW-1:0] measured_q, elapsed_ms_q;

  pc_t   pc_q, pc_d;
  ctrl_t ctrl, ctrl_dp;
  logic  s_fire, out_block, out_load, div_busy;

  logic [DriveW-1:0] dp_drive, m_data_q, m_data_d;
  logic              dp_sat, m_user_q, m_user_d, m_valid_q, m_valid_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SetpointReset;
      gain_p_q   <= GainPReset;
      gain_i_q   <= GainIReset;
      gain_d_q   <= GainDReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SETPOINT: setpoint_q <= cfg_data_i;
        REG_GAIN_P:   gain_p_q   <= cfg_data_i;
        REG_GAIN_I:   gain_i_q   <= cfg_data_i;
        REG_GAIN_D:   gain_d_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pidvdt_ucode u_ucode (
    .pc_i   (pc_q),
    .ctrl_o (ctrl)
  );

  assign out_block = m_valid_q & ~m_axis_tready;
  assign s_fire    = s_axis_tvalid & s_axis_tready;

  // sequencer outputs
  always_comb begin
    s_axis_tready = (ctrl.seq == SEQ_ACCEPT);
    out_load      = (ctrl.seq == SEQ_WAIT_OUT) & ~out_block;
    ctrl_dp       = ctrl;
    // state updates of the last step wait for a free output register
    if (ctrl.seq == SEQ_WAIT_OUT && out_block) begin
      ctrl_dp.st_op = ST_HOLD;
    end
  end

  // next step
  always_comb begin
    case (ctrl.seq)
      SEQ_NEXT:     pc_d = pc_t'(pc_q + 1'b1);
      SEQ_ACCEPT: begin
        if (!s_fire) begin
          pc_d = pc_q;
        end else begin
          pc_d = s_axis_tuser ? ctrl.target : pc_t'(pc_q + 1'b1);
        end
      end
      SEQ_WAIT_DIV: pc_d = div_busy ? pc_q : pc_t'(pc_q + 1'b1);
      SEQ_WAIT_OUT: pc_d = out_block ? pc_q : ctrl.target;
      default:      pc_d = PcIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  // operand capture
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      measured_q   <= s_axis_tdata[ValW-1:0];
      elapsed_ms_q <= s_axis_tdata[TDataInW-1:ValW];
    end
  end

  pidvdt_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl_dp),
    .setpoint_i   (setpoint_q),
    .gain_p_i     (gain_p_q),
    .gain_i_i     (gain_i_q),
    .gain_d_i     (gain_d_q),
    .measured_i   (measured_q),
    .elapsed_ms_i (elapsed_ms_q),
    .div_busy_o   (div_busy),
    .drive_o      (dp_drive),
    .saturated_o  (dp_sat)
  );

  // output register
  always_comb begin
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    if (out_load) begin
      m_valid_d = 1'b1;
      if (ctrl.st_op == ST_CLEAR) begin
        m_data_d = '0;
        m_user_d = 1'b0;
      end else begin
        m_data_d = dp_drive;
        m_user_d = dp_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `PIDVDT_ASSERT(a_one_in_flight, s_fire |=> !s_axis_tready, "second word taken while busy")
  `PIDVDT_ASSERT_NEVER(a_idle_div, s_axis_tready && div_busy, "divider running while idle")
  `PIDVDT_ASSERT(a_valid_src, $rose(m_valid_q) |-> $past(ctrl.seq == SEQ_WAIT_OUT), "result without output step")

endmodule
